// ===== rtl/wit_pkg.sv =====
package wit_pkg;

	// Four bytes of one segment or tile row, element 0 in the low byte
	typedef logic [3:0][7:0] row_t;

	// Configuration register indexes
	localparam logic REG_TWO_DIM = 1'b0;
	localparam logic REG_OFFSET  = 1'b1;

	// Offset-binary bias, added or subtracted modulo 256
	localparam logic [7:0] BIAS_OFFSET = 8'h80;
	localparam logic [7:0] BIAS_NONE   = 8'h00;

	// Last row of a 4x4 tile
	localparam logic [1:0] ROW_LAST = 2'd3;

	// Output row whose column combination is a sum; every other row is a difference
	localparam logic [1:0] ROW_SUM = 2'd1;

	// Row address of the second operand for output rows 0-1 and 2-3
	localparam logic [1:0] ROW_B_LO = 2'd2;
	localparam logic [1:0] ROW_B_HI = 2'd1;

	// F(2,3) input transform of four bytes: bias in, transform, bias out
	function automatic row_t xform4(row_t d, logic [7:0] bias_in, logic [7:0] bias_out);
		row_t s;
		row_t r;
		for (int i = 0; i < 4; i++) begin
			s[i] = d[i] + bias_in;
		end
		r[0] = s[0] - s[2] + bias_out;
		r[1] = s[1] + s[2] + bias_out;
		r[2] = s[2] - s[1] + bias_out;
		r[3] = s[3] - s[1] + bias_out;
		return r;
	endfunction

	// Column pass for output row k: combine two held rows element by element
	function automatic row_t col_comb(row_t a, row_t b, logic [1:0] k, logic [7:0] bias_out);
		row_t r;
		for (int w = 0; w < 4; w++) begin
			if (k == ROW_SUM) begin
				r[w] = a[w] + b[w] + bias_out;
			end else begin
				r[w] = a[w] - b[w] + bias_out;
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/wit_ram.sv =====
module wit_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word with registered output held while idle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/winograd_input_transform_int8.sv =====
// Winograd F(2,3) input transform for int8 data. Each input word is four bytes:
// one segment in 1D mode, one row of a 4x4 tile in 2D mode. In 2D mode a row is
// row-transformed and written to a two-bank tile memory as it is taken, so rows
// are taken back to back; after the fourth row the filled bank is drained through
// two read ports, one output row per cycle while the output does not stall, while
// the next tile fills the other bank. Each output row passes through the registered
// memory read into stage 2 and then the column pass into the output register. A 1D
// segment is transformed as it is taken and passes through stage 2 and the output
// register as one output word. A segment waits while a tile drain is still issuing
// reads; the fourth row of the next tile waits only while output stalls hold the
// drain back. Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
// Changing mode keeps a partly filled tile, which resumes when 2D mode returns.
module winograd_input_transform_int8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_0,
	input  logic [7:0] in_1,
	input  logic [7:0] in_2,
	input  logic [7:0] in_3,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_0,
	output logic [7:0] out_1,
	output logic [7:0] out_2,
	output logic [7:0] out_3,
	output logic [1:0] row_index,
	output logic       last
);

	logic             two_dim_q;
	logic             offset_q;
	logic [1:0]       rows_seen_q;
	logic             bank_q;
	logic             drain_act_q;
	logic [1:0]       drain_k_q;
	logic             drain_bank_q;
	logic             vld_s2;
	logic             oned_s2;
	logic [1:0]       k_s2;
	wit_pkg::row_t    res_s2;
	logic             out_vld_q;
	wit_pkg::row_t    out_row_q;
	logic [1:0]       row_index_q;
	logic             last_q;

	logic [7:0]       bias;
	wit_pkg::row_t    in_row;
	wit_pkg::row_t    row_wdata;
	wit_pkg::row_t    oned_res;
	wit_pkg::row_t    rd_a;
	wit_pkg::row_t    rd_b;
	logic             adv_s2;
	logic             s2_free;
	logic             tile_done;
	logic             acc;
	logic             row_we;
	logic             issue;
	logic             drain_end;
	logic             load_s2;
	logic [2:0]       waddr;
	logic [2:0]       raddr_a;
	logic [2:0]       raddr_b;
	logic [1:0]       row_b;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_dim_q <= 1'b1;
			offset_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				wit_pkg::REG_TWO_DIM: two_dim_q <= cfg_data;
				wit_pkg::REG_OFFSET:  offset_q  <= cfg_data;
				default:              ;
			endcase
		end
	end

	// Row transform of the incoming word
	assign bias      = offset_q ? wit_pkg::BIAS_OFFSET : wit_pkg::BIAS_NONE;
	assign in_row    = {in_3, in_2, in_1, in_0};
	assign row_wdata = wit_pkg::xform4(in_row, bias, wit_pkg::BIAS_NONE);
	assign oned_res  = wit_pkg::xform4(in_row, bias, bias);

	// Handshake and interlock: hold a tile's last row or a segment while a drain issues
	assign adv_s2    = vld_s2 && (!out_vld_q || out_ready);
	assign s2_free   = !vld_s2 || adv_s2;
	assign tile_done = (rows_seen_q == wit_pkg::ROW_LAST);
	assign issue     = drain_act_q && s2_free;
	assign drain_end = issue && (drain_k_q == wit_pkg::ROW_LAST);
	assign in_ready  = two_dim_q ? (!tile_done || !drain_act_q || drain_end)
	                             : (!drain_act_q && s2_free);
	assign acc       = in_valid && in_ready;
	assign row_we    = acc && two_dim_q;
	assign load_s2   = issue || (acc && !two_dim_q);

	// Tile memory addresses: {bank, row}
	assign waddr   = {bank_q, rows_seen_q};
	assign row_b   = (drain_k_q < wit_pkg::ROW_B_LO) ? wit_pkg::ROW_B_LO : wit_pkg::ROW_B_HI;
	assign raddr_a = {drain_bank_q, drain_k_q};
	assign raddr_b = {drain_bank_q, row_b};

	// Two mirrored copies give two read ports
	wit_ram #(.WIDTH(32), .DEPTH(8)) u_ram_a (
		.clk   (clk),
		.we    (row_we),
		.waddr (waddr),
		.wdata (row_wdata),
		.re    (issue),
		.raddr (raddr_a),
		.rdata (rd_a)
	);

	wit_ram #(.WIDTH(32), .DEPTH(8)) u_ram_b (
		.clk   (clk),
		.we    (row_we),
		.waddr (waddr),
		.wdata (row_wdata),
		.re    (issue),
		.raddr (raddr_b),
		.rdata (rd_b)
	);

	// Advance the drain; on the fourth row swap banks and start the next drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_seen_q  <= 2'd0;
			bank_q       <= 1'b0;
			drain_act_q  <= 1'b0;
			drain_k_q    <= 2'd0;
			drain_bank_q <= 1'b0;
		end else begin
			if (issue) begin
				drain_k_q <= drain_k_q + 2'd1;
				if (drain_k_q == wit_pkg::ROW_LAST) begin
					drain_act_q <= 1'b0;
				end
			end
			if (row_we) begin
				rows_seen_q <= rows_seen_q + 2'd1;
				if (tile_done) begin
					bank_q       <= ~bank_q;
					drain_act_q  <= 1'b1;
					drain_k_q    <= 2'd0;
					drain_bank_q <= bank_q;
				end
			end
		end
	end

	// Stage 2 control: memory read in flight or a finished segment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (load_s2) begin
			vld_s2 <= 1'b1;
		end else if (adv_s2) begin
			vld_s2 <= 1'b0;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (load_s2) begin
			oned_s2 <= !issue;
			k_s2    <= drain_k_q;
			res_s2  <= oned_res;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s2) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Column pass into the output register
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			if (oned_s2) begin
				out_row_q   <= res_s2;
				row_index_q <= 2'd0;
				last_q      <= 1'b1;
			end else begin
				out_row_q   <= wit_pkg::col_comb(rd_a, rd_b, k_s2, bias);
				row_index_q <= k_s2;
				last_q      <= (k_s2 == wit_pkg::ROW_LAST);
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_0     = out_row_q[0];
	assign out_1     = out_row_q[1];
	assign out_2     = out_row_q[2];
	assign out_3     = out_row_q[3];
	assign row_index = row_index_q;
	assign last      = last_q;

endmodule
